### hw/rtl/maa_pkg.sv
// Package for the modular arithmetic unit: widths, opcodes, shared types.
// No dependencies.
package maa_pkg;
    localparam int MOD_BITS = 32;
    localparam int VAL_BITS = 64;
    localparam int CNT_BITS = 7;

    typedef enum logic [2:0] {
        OP_RED = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_POW = 3'd5
    } t_opcode;

    // Request to the bit-serial modular multiplier
    typedef struct packed {
        logic                start;
        logic [MOD_BITS-1:0] a;
        logic [MOD_BITS-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                done;
        logic [MOD_BITS-1:0] p;
    } t_mul_rsp;
endpackage

### hw/rtl/maa_if.sv
// Valid/ready channel interfaces for the modular arithmetic unit.
// Depends on maa_pkg.
interface maa_in_if import maa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          opcode;
    logic [MOD_BITS-1:0] operand_a;
    logic [MOD_BITS-1:0] operand_b;
    logic signed [VAL_BITS-1:0] signed_value;
    modport source (output valid, opcode, operand_a, operand_b, signed_value, input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, signed_value, output ready);
endinterface

interface maa_out_if import maa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] result;
    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

interface maa_cfg_if import maa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/maa_mulmod.sv
// Bit-serial modular multiplier: Horner double-and-add, one bit of b a cycle.
// Depends on maa_pkg. Inputs must be below the modulus.
module maa_mulmod import maa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [MOD_BITS-1:0] i_mod,
    input  t_mul_req            i_req,
    output t_mul_rsp            o_rsp
);
    logic [MOD_BITS-1:0] r_acc, r_a, r_b;
    logic [5:0]          r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [MOD_BITS:0]   dbl, dbl_r, add, add_r;

    // Double then conditionally add a, each reduced by one subtract
    always_comb begin
        dbl   = {r_acc, 1'b0};
        dbl_r = (dbl >= {1'b0, i_mod}) ? dbl - {1'b0, i_mod} : dbl;
        add   = dbl_r + {1'b0, r_a};
        add_r = (add >= {1'b0, i_mod}) ? add - {1'b0, i_mod} : add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_acc  <= '0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_cnt  <= 6'(MOD_BITS);
            end else if (r_busy) begin
                r_acc <= r_b[MOD_BITS-1] ? add_r[MOD_BITS-1:0] : dbl_r[MOD_BITS-1:0];
                r_b   <= {r_b[MOD_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_busy ? add_r[MOD_BITS-1:0] : r_acc;
endmodule

### hw/rtl/maa_reduce.sv
// Bit-serial reducer: shifts a value in MSB first, one subtract per cycle.
// Depends on maa_pkg.
module maa_reduce import maa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [MOD_BITS-1:0] i_mod,
    input  logic                i_start,
    input  logic [VAL_BITS-1:0] i_val,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_rem
);
    logic [VAL_BITS-1:0] r_val;
    logic [MOD_BITS-1:0] r_rem;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic [MOD_BITS:0]   sh, sh_r;

    always_comb begin
        sh   = {r_rem, r_val[VAL_BITS-1]};
        sh_r = (sh >= {1'b0, i_mod}) ? sh - {1'b0, i_mod} : sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_val  <= i_val;
                r_rem  <= '0;
                r_cnt  <= CNT_BITS'(VAL_BITS);
            end else if (r_busy) begin
                r_rem <= sh_r[MOD_BITS-1:0];
                r_val <= {r_val[VAL_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_rem = r_rem;
endmodule

### hw/rtl/modular_arith_alu.sv
// Modular arithmetic unit, one item at a time through a bit-serial reducer and multiplier.
// Every operation first reduces operand a, operand b and the value in turn; mul then runs
// one multiply, while div and pow run a square-and-multiply loop on the multiplier. A new item
// is taken only after the result of the last one has been accepted.
// Reset (synchronous, active low) sets the modulus to 2.
// Depends on maa_pkg, maa_if, maa_reduce, maa_mulmod.
module modular_arith_alu import maa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    maa_cfg_if.sink   cfg,
    maa_in_if.sink    in_ch,
    maa_out_if.source out_ch
);
    typedef enum logic [3:0] {
        S_IDLE, S_RA, S_RB, S_RV, S_DISP, S_MSQ, S_MMUL, S_FIN, S_OUT
    } t_state;

    t_state              r_state;
    logic [MOD_BITS-1:0] r_mod, r_a, r_b, r_acc, r_base, r_res, r_vrem;
    logic [VAL_BITS-1:0] r_val, r_exp;
    logic [2:0]          r_op;
    logic                r_neg, r_mul_busy, r_sq_phase, r_fin_mul;
    logic                red_start, red_done;
    logic [VAL_BITS-1:0] red_val;
    logic [MOD_BITS-1:0] red_rem;
    t_mul_req            mreq;
    t_mul_rsp            mrsp;
    logic [MOD_BITS:0]   sum, sum_r;
    logic [MOD_BITS-1:0] subv, negv;

    maa_reduce u_red (.i_clk, .i_rst_n, .i_mod(r_mod), .i_start(red_start),
                      .i_val(red_val), .o_done(red_done), .o_rem(red_rem));
    maa_mulmod u_mul (.i_clk, .i_rst_n, .i_mod(r_mod), .i_req(mreq), .o_rsp(mrsp));

    assign cfg.ready    = (r_state == S_IDLE);
    assign in_ch.ready  = (r_state == S_IDLE);
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.result = r_res;

    // Combinational add/sub on reduced residues, and the negated value residue
    always_comb begin
        sum   = {1'b0, r_a} + {1'b0, r_b};
        sum_r = (sum >= {1'b0, r_mod}) ? sum - {1'b0, r_mod} : sum;
        subv  = (r_a >= r_b) ? r_a - r_b : r_a + r_mod - r_b;
        negv  = (r_vrem == '0) ? '0 : r_mod - r_vrem;
    end

    always_comb begin
        red_start = 1'b0;
        red_val   = r_val;
        if (in_ch.valid && in_ch.ready) begin
            red_start = 1'b1;
            red_val   = {{(VAL_BITS-MOD_BITS){1'b0}}, in_ch.operand_a};
        end else if (r_state == S_RA && red_done) begin
            red_start = 1'b1;
            red_val   = {{(VAL_BITS-MOD_BITS){1'b0}}, r_b};
        end else if (r_state == S_RB && red_done) begin
            red_start = 1'b1;
            red_val   = r_val[VAL_BITS-1] ? (~r_val + 1'b1) : r_val;
        end
    end

    // Control sequencer: reduce operands and value, then dispatch to reduce/add/sub/mul or the power loop (pow, div)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mod      <= MOD_BITS'(2);
            mreq.start <= 1'b0;
            r_mul_busy <= 1'b0;
        end else begin
            mreq.start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (cfg.valid) r_mod <= cfg.data;
                    if (in_ch.valid) begin
                        r_op    <= in_ch.opcode;
                        r_b     <= in_ch.operand_b;
                        r_val   <= in_ch.signed_value;
                        r_state <= S_RA;
                    end
                end
                S_RA: if (red_done) begin
                    r_a     <= red_rem;
                    r_state <= S_RB;
                end
                S_RB: if (red_done) begin
                    r_b     <= red_rem;
                    r_neg   <= r_val[VAL_BITS-1];
                    r_state <= S_RV;
                end
                S_RV: if (red_done) begin
                    r_vrem  <= red_rem;
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    r_acc      <= MOD_BITS'(1);
                    r_fin_mul  <= 1'b0;
                    r_sq_phase <= 1'b0;
                    r_state    <= S_OUT;
                    priority if (r_mod < MOD_BITS'(2)) r_res <= '0;
                    else if (r_op == OP_RED) r_res <= r_neg ? negv : r_vrem;
                    else if (r_op == OP_ADD) r_res <= sum_r[MOD_BITS-1:0];
                    else if (r_op == OP_SUB) r_res <= subv;
                    else if (r_op == OP_MUL) begin
                        mreq.a <= r_a; mreq.b <= r_b; mreq.start <= 1'b1;
                        r_state <= S_FIN;
                    end else if (r_op == OP_DIV) begin
                        if (r_b == '0) r_res <= '0;
                        else begin
                            r_base    <= r_b;
                            r_exp     <= {{(VAL_BITS-MOD_BITS){1'b0}}, r_mod - MOD_BITS'(2)};
                            r_fin_mul <= 1'b1;
                            r_state   <= S_MMUL;
                        end
                    end else if (r_op == OP_POW) begin
                        if (r_neg || r_val == '0) r_res <= MOD_BITS'(1);
                        else begin
                            r_base  <= r_a;
                            r_exp   <= r_val;
                            r_state <= S_MMUL;
                        end
                    end else r_res <= '0;
                end
                // Square-and-multiply: multiply step when exponent bit set, then square; div ends by multiplying by a
                S_MMUL: begin
                    if (!r_mul_busy) begin
                        if (r_exp == '0) begin
                            if (r_fin_mul) begin
                                mreq.a <= r_a; mreq.b <= r_acc; mreq.start <= 1'b1;
                                r_state <= S_FIN;
                            end else begin
                                r_res   <= r_acc;
                                r_state <= S_OUT;
                            end
                        end else if (r_exp[0] && !r_sq_phase) begin
                            mreq.a <= r_acc; mreq.b <= r_base; mreq.start <= 1'b1;
                            r_mul_busy <= 1'b1;
                        end else begin
                            mreq.a <= r_base; mreq.b <= r_base; mreq.start <= 1'b1;
                            r_mul_busy <= 1'b1;
                            r_sq_phase <= 1'b1;
                        end
                    end else if (mrsp.done) begin
                        r_mul_busy <= 1'b0;
                        if (r_sq_phase) begin
                            r_base     <= mrsp.p;
                            r_exp      <= r_exp >> 1;
                            r_sq_phase <= 1'b0;
                        end else begin
                            r_acc      <= mrsp.p;
                            r_sq_phase <= 1'b1;
                        end
                    end
                end
                S_FIN: if (mrsp.done) begin
                    r_res   <= mrsp.p;
                    r_state <= S_OUT;
                end
                S_OUT: if (out_ch.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
